// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/drt_pkg.sv =====
// Package for the dirty rectangle tracker: types, widths, controller states.
// Depends on nothing; imported by all tracker modules.
`timescale 1ns / 1ps
package drt_pkg;
	localparam int MaxRects = 16;
	localparam int IdxW = $clog2(MaxRects);
	localparam int CntW = $clog2(MaxRects + 1);
	localparam int CoordW = 13;
	localparam int InW = 16;
	localparam int RegIdxW = 1;
	localparam logic [RegIdxW-1:0] RegScreenWidth = 1'b0;
	localparam logic [RegIdxW-1:0] RegScreenHeight = 1'b1;

	// input word operations
	localparam logic OpAdd = 1'b0;
	localparam logic OpDrain = 1'b1;

	typedef struct packed {
		logic [CoordW-1:0] tall;
		logic [CoordW-1:0] wide;
		logic [CoordW-1:0] top;
		logic [CoordW-1:0] left;
	} rect_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_EMIT,
		ST_EMPTY
	} drt_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic add;        // store clamped word, or a full-screen entry if list full
		logic clr_ij;     // restart pair scan at (0,1)
		logic step_ij;    // advance pair scan
		logic merge;      // grow i, start shifting at j
		logic shift_step; // move one entry down
		logic emit_load;  // load output register with entry n
		logic emit_empty; // load output register with empty marker
		logic clr_n;      // zero emit index
	} drt_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic overlap;   // pair (i,j) overlaps
		logic scan_done; // no further pair exists
		logic shift_done;
		logic emit_last; // entry n is the last one
		logic empty;     // list count is zero
		logic out_busy;  // output register holds a word not taken
	} drt_sts_t;
endpackage

// ===== rtl/drt_ctrl.sv =====
// Controller state machine for the tracker: add, merge scan, shift, emit, empty marker.
// Depends on drt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_op,
	input  drt_pkg::drt_sts_t sts,
	output drt_pkg::drt_cmd_t cmd,
	output logic in_ready
);
	import drt_pkg::*;

	drt_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_op == OpDrain) begin
					state_d = sts.empty ? ST_EMPTY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_EMIT;
				end else if (sts.overlap) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.add = in_fire && in_op == OpAdd;
				cmd.clr_ij = 1'b1;
				cmd.clr_n = 1'b1;
			end
			ST_SCAN: begin
				if (!sts.scan_done) begin
					cmd.merge = sts.overlap;
					cmd.step_ij = !sts.overlap;
				end
			end
			ST_SHIFT: begin
				cmd.shift_step = !sts.shift_done;
				cmd.clr_ij = sts.shift_done;
			end
			ST_EMIT: begin
				cmd.emit_load = !sts.out_busy;
			end
			ST_EMPTY: begin
				cmd.emit_empty = !sts.out_busy;
			end
			default: ;
		endcase
	end

	`CHK_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
	`CHK_IMPL(a_one_load, clk, arst_n, cmd.emit_load, !cmd.merge && !cmd.add, "load overlaps work")
	`CHK_NEXT(a_drain_leaves, clk, arst_n, in_fire && in_op == OpDrain, state_q != ST_IDLE, "drain ignored")
endmodule

// ===== rtl/drt_datapath.sv =====
// Datapath for the tracker: clamp, rectangle store, pair scan, merge, output.
// Depends on drt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drt_datapath (
	input  logic clk,
	input  logic arst_n,
	input  drt_pkg::drt_cmd_t cmd,
	output drt_pkg::drt_sts_t sts,
	input  logic [drt_pkg::CoordW-1:0] scr_w,
	input  logic [drt_pkg::CoordW-1:0] scr_h,
	input  logic [drt_pkg::InW-1:0] in_left,
	input  logic [drt_pkg::InW-1:0] in_top,
	input  logic [drt_pkg::InW-1:0] in_wide,
	input  logic [drt_pkg::InW-1:0] in_tall,
	output drt_pkg::rect_t out_rect,
	output logic out_empty,
	output logic out_last,
	output logic out_valid,
	input  logic out_ready
);
	import drt_pkg::*;

	localparam int WW = InW + 3;

	rect_t store_q [MaxRects];
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] i_q, j_q, k_q, n_q;
	logic out_valid_q, out_empty_q, out_last_q;
	rect_t out_rect_q;

	// clamp one axis; widths are wide enough to never wrap
	function automatic logic [2*CoordW-1:0] clamp_axis(
		input logic [InW-1:0] p_in, input logic [InW-1:0] l_in,
		input logic [CoordW-1:0] lim);
		logic signed [WW-1:0] p, l, m;
		begin
			p = WW'(signed'(p_in));
			l = WW'(signed'(l_in));
			m = WW'(lim);
			if (p < 0) begin
				l = l + p;
				p = '0;
			end
			if (p + l > m) begin
				l = m - p;
			end
			if (l < 0) begin
				l = '0;
			end
			if (p > m) begin
				p = m;
			end
			clamp_axis = {l[CoordW-1:0], p[CoordW-1:0]};
		end
	endfunction

	logic [2*CoordW-1:0] cx, cy;
	assign cx = clamp_axis(in_left, in_wide, scr_w);
	assign cy = clamp_axis(in_top, in_tall, scr_h);

	// pair overlap and bounding box
	rect_t ra, rb, rm;
	logic [CoordW:0] ax2, bx2, ay2, by2, x2, y2;
	logic ovl;
	assign ra = store_q[i_q];
	assign rb = store_q[j_q];
	always_comb begin
		ax2 = {1'b0, ra.left} + {1'b0, ra.wide};
		bx2 = {1'b0, rb.left} + {1'b0, rb.wide};
		ay2 = {1'b0, ra.top} + {1'b0, ra.tall};
		by2 = {1'b0, rb.top} + {1'b0, rb.tall};
		ovl = !(ax2 <= {1'b0, rb.left} || bx2 <= {1'b0, ra.left} ||
			ay2 <= {1'b0, rb.top} || by2 <= {1'b0, ra.top});
		rm.left = (ra.left < rb.left) ? ra.left : rb.left;
		rm.top = (ra.top < rb.top) ? ra.top : rb.top;
		x2 = (ax2 > bx2) ? ax2 : bx2;
		y2 = (ay2 > by2) ? ay2 : by2;
		rm.wide = CoordW'(x2 - {1'b0, rm.left});
		rm.tall = CoordW'(y2 - {1'b0, rm.top});
	end

	// k_last: every entry above the removed one has moved down (count already reduced)
	logic j_last, i_last, k_last, n_last;
	assign j_last = ({1'b0, j_q} + 1'b1) >= cnt_q;
	assign i_last = ({1'b0, i_q} + 2'd2) >= cnt_q;
	assign k_last = {1'b0, k_q} >= cnt_q;
	assign n_last = ({1'b0, n_q} + 1'b1) >= cnt_q;

	assign sts.overlap = ovl;
	assign sts.scan_done = (cnt_q < CntW'(2)) || (j_last && i_last && !ovl);
	assign sts.shift_done = k_last;
	assign sts.emit_last = n_last;
	assign sts.empty = (cnt_q == '0);
	assign sts.out_busy = out_valid_q && !out_ready;

	// store writes: add, merge grow, shift down
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			if (cnt_q >= CntW'(MaxRects)) begin
				store_q[0] <= '{tall: scr_h, wide: scr_w, top: '0, left: '0};
			end else begin
				store_q[cnt_q[IdxW-1:0]] <= '{tall: cy[2*CoordW-1:CoordW],
					wide: cx[2*CoordW-1:CoordW], top: cy[CoordW-1:0], left: cx[CoordW-1:0]};
			end
		end
		if (cmd.merge) begin
			store_q[i_q] <= rm;
		end
		if (cmd.shift_step) begin
			store_q[k_q] <= store_q[k_q + 1'b1];
		end
	end

	// count and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			if (cmd.add) begin
				cnt_q <= (cnt_q >= CntW'(MaxRects)) ? CntW'(1) : cnt_q + 1'b1;
			end
			if (cmd.clr_ij) begin
				i_q <= '0;
				j_q <= IdxW'(1);
			end else if (cmd.step_ij) begin
				if (j_last) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + IdxW'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.merge) begin
				k_q <= j_q;
				cnt_q <= cnt_q - 1'b1;
			end else if (cmd.shift_step) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.clr_n) begin
				n_q <= '0;
			end else if (cmd.emit_load) begin
				n_q <= n_q + 1'b1;
				if (n_last) begin
					cnt_q <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_rect_q <= store_q[n_q];
			out_empty_q <= 1'b0;
			out_last_q <= n_last;
		end else if (cmd.emit_empty) begin
			out_rect_q <= '0;
			out_empty_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign out_rect = out_rect_q;
	assign out_empty = out_empty_q;
	assign out_last = out_last_q;
	assign out_valid = out_valid_q;

	`CHK_IMPL(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= CntW'(MaxRects), "count overflow")
	`CHK_IMPL(a_merge_pair, clk, arst_n, cmd.merge, i_q < j_q && {1'b0, j_q} < cnt_q, "bad pair")
	`CHK_IMPL(a_load_free, clk, arst_n, cmd.emit_load, !sts.out_busy, "output overwrite")
endmodule

// ===== rtl/dirty_rect_tracker_unit.sv =====
// Dirty rectangle tracker: an add word is stored in the list; a drain walks the list.
// Drain: it tries each pair, merges an overlapping pair and shifts the entries above it down,
// then loads the first result; result words follow one per cycle while m_tready is high.
// Throughput: one add word per cycle; input stalls until the last result word is loaded.
// Reset (arst_n, async low): list empty, screen 1024 x 768, no pending word.
`timescale 1ns / 1ps
module dirty_rect_tracker_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// op
	input  logic s_tuser,
	// rect_left[15:0], rect_top[31:16], rect_wide[47:32], rect_tall[63:48]
	input  logic [63:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// out_left[12:0], out_top[25:13], out_wide[38:26], out_tall[51:39], 0
	output logic [55:0] m_tdata,
	// list_empty
	output logic m_tuser,
	output logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import drt_pkg::*;

	logic [CoordW-1:0] scr_w_q, scr_h_q;
	drt_cmd_t cmd;
	drt_sts_t sts;
	rect_t orect;
	logic oempty, in_fire;
	logic [RegIdxW-1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= CoordW'(1024);
			scr_h_q <= CoordW'(768);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (ridx)
				RegScreenWidth: scr_w_q <= pwdata[CoordW-1:0];
				RegScreenHeight: scr_h_q <= pwdata[CoordW-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (ridx)
			RegScreenWidth: prdata = {19'd0, scr_w_q};
			RegScreenHeight: prdata = {19'd0, scr_h_q};
			default: prdata = '0;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	drt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(s_tuser),
		.sts(sts), .cmd(cmd), .in_ready(s_tready)
	);

	drt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.scr_w(scr_w_q), .scr_h(scr_h_q),
		.in_left(s_tdata[15:0]), .in_top(s_tdata[31:16]),
		.in_wide(s_tdata[47:32]), .in_tall(s_tdata[63:48]),
		.out_rect(orect), .out_empty(oempty), .out_last(m_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready)
	);

	assign m_tdata = {4'd0, orect.tall, orect.wide, orect.top, orect.left};
	assign m_tuser = oempty;
endmodule
